@@ rtl/bf3_pkg.sv @@
`default_nettype none

package bf3_pkg;

    // Frame limits; line store depth and cursor widths follow from these
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    // input row runs up to height + 1 while draining
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    // window sum of nine pixels
    localparam int SUM_W  = $clog2(9 * 255 + 1);

    // Register defaults
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

    // Register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_of_frame;
    } t_out_item;

    // Per-item control worked out by the front
    typedef struct packed {
        logic       pre;        // sum taken from window before the shift
        logic       produced;   // item yields an output pixel
        logic       last;       // final output of the frame
        logic [2:0] col_mask;   // window columns inside the frame
        logic [2:0] row_mask;   // window rows inside the frame
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [PIX_W-1:0] up_px;
        logic [PIX_W-1:0] mid_px;
        logic [PIX_W-1:0] new_px;
    } t_q_item;

endpackage

`default_nettype wire

@@ rtl/bf3_ram.sv @@
`default_nettype none

module bf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/bf3_front.sv @@
`default_nettype none

module bf3_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [bf3_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bf3_pkg::t_in_item           i_in_data,
    output logic                             o_push,
    output bf3_pkg::t_q_item                 o_push_data,
    input  wire logic                        i_push_ready
);

    localparam int RS_W = bf3_pkg::ROW_W + 2;
    localparam int LS_W = 2 * bf3_pkg::PIX_W;

    // Frame size registers
    logic [bf3_pkg::CFG_W-1:0] r_cfg_w;
    logic [bf3_pkg::CFG_W-1:0] r_cfg_h;

    // Input cursor
    logic [bf3_pkg::COL_W-1:0] r_col, n_col;
    logic [bf3_pkg::ROW_W-1:0] r_row, n_row;

    // Line store read stage
    logic                        r_s1_valid;
    bf3_pkg::t_ctl               r_s1_ctl;
    logic [bf3_pkg::PIX_W-1:0]   r_s1_px;
    logic [bf3_pkg::COL_W-1:0]   r_s1_addr;
    logic                        r_fwd_hit;
    logic [LS_W-1:0]             r_fwd_data;

    logic [bf3_pkg::DIM_W-1:0]   eff_w;
    logic [bf3_pkg::HGT_W-1:0]   eff_h;
    logic                        complete;
    logic                        accept;
    logic                        advance;
    logic                        s1_go;
    logic [bf3_pkg::PIX_W-1:0]   in_px;
    bf3_pkg::t_ctl               ctl;
    logic signed [RS_W-1:0]      row_base;
    logic signed [RS_W-1:0]      h_s;
    logic signed [RS_W-1:0]      row_t [3];
    logic [LS_W-1:0]             rd_data;
    logic [LS_W-1:0]             ls_eff;

    // Clamp the size registers into the supported range
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = bf3_pkg::DIM_W'(1);
        end else if (32'(r_cfg_w) > 32'(bf3_pkg::MAX_WIDTH)) begin
            eff_w = bf3_pkg::DIM_W'(bf3_pkg::MAX_WIDTH);
        end else begin
            eff_w = bf3_pkg::DIM_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = bf3_pkg::HGT_W'(1);
        end else if (32'(r_cfg_h) > 32'(bf3_pkg::MAX_HEIGHT)) begin
            eff_h = bf3_pkg::HGT_W'(bf3_pkg::MAX_HEIGHT);
        end else begin
            eff_h = bf3_pkg::HGT_W'(r_cfg_h);
        end
    end

    // Classify: pixels are taken until the frame is in, flushes after
    assign complete   = 32'(r_row) >= 32'(eff_h);
    assign s1_go      = r_s1_valid && i_push_ready;
    assign o_in_ready = !r_s1_valid || s1_go;
    assign accept     = i_in_valid && o_in_ready;
    assign advance    = accept && ((i_in_data.command == bf3_pkg::CMD_FLUSH) ? complete
                                                                             : !complete);
    assign in_px      = (i_in_data.command == bf3_pkg::CMD_FLUSH) ? '0 : i_in_data.pixel_in;

    // Output target, edge masks and end of frame for this step
    assign h_s      = RS_W'(eff_h);
    assign row_base = $signed(RS_W'(r_row)) - ((r_col == '0) ? RS_W'(3) : RS_W'(2));

    always_comb begin
        ctl     = '0;
        ctl.pre = (r_col == '0);
        if (ctl.pre) begin
            ctl.produced = 32'(r_row) >= 32'(2);
            ctl.last     = 32'(r_row) == 32'(eff_h) + 32'(1);
            ctl.col_mask = (32'(eff_w) >= 32'(2)) ? 3'b110 : 3'b100;
        end else begin
            ctl.produced = (r_row != '0);
            ctl.last     = 1'b0;
            ctl.col_mask = (32'(r_col) >= 32'(2)) ? 3'b111 : 3'b110;
        end
        for (int k = 0; k < 3; k++) begin
            row_t[k]        = row_base + RS_W'(k);
            ctl.row_mask[k] = !row_t[k][RS_W-1] && (row_t[k] < h_s);
        end
    end

    // Cursor step, back to the origin after the final output
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (advance) begin
            if (ctl.last) begin
                n_col = '0;
                n_row = '0;
            end else if (32'(r_col) + 32'(1) >= 32'(eff_w)) begin
                n_col = '0;
                n_row = r_row + bf3_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + bf3_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bf3_pkg::FRAME_WIDTH_RST;
            r_cfg_h <= bf3_pkg::FRAME_HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cfg_we) begin
            // any size write restarts the frame
            unique case (i_cfg_index)
                bf3_pkg::REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                bf3_pkg::REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Read stage payload; forward when the write of the previous item lands on this address
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ctl   <= ctl;
            r_s1_px    <= in_px;
            r_s1_addr  <= r_col;
            r_fwd_hit  <= s1_go && (r_col == r_s1_addr);
            r_fwd_data <= {ls_eff[bf3_pkg::PIX_W-1:0], r_s1_px};
        end
    end

    // Both line stores in one word: upper in the high byte, middle in the low byte
    assign ls_eff = r_fwd_hit ? r_fwd_data : rd_data;

    bf3_ram #(
        .WIDTH (LS_W),
        .DEPTH (bf3_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({ls_eff[bf3_pkg::PIX_W-1:0], r_s1_px}),
        .i_rd_en   (advance),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    // Hand the step to the queue
    assign o_push             = s1_go;
    assign o_push_data.ctl    = r_s1_ctl;
    assign o_push_data.up_px  = ls_eff[LS_W-1:bf3_pkg::PIX_W];
    assign o_push_data.mid_px = ls_eff[bf3_pkg::PIX_W-1:0];
    assign o_push_data.new_px = r_s1_px;

endmodule

`default_nettype wire

@@ rtl/bf3_fifo.sv @@
`default_nettype none

module bf3_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bf3_pkg::t_q_item i_push_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output bf3_pkg::t_q_item      o_data,
    input  wire logic             i_pop
);

    localparam int PTR_W = (bf3_pkg::QUEUE_DEPTH > 1) ? $clog2(bf3_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bf3_pkg::QUEUE_DEPTH + 1);

    bf3_pkg::t_q_item r_slot [bf3_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic push_ok;
    logic pop_ok;

    assign o_ready = (32'(r_count) < 32'(bf3_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (32'(r_wr_ptr) == bf3_pkg::QUEUE_DEPTH - 1) ? '0
                                                                       : r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (32'(r_rd_ptr) == bf3_pkg::QUEUE_DEPTH - 1) ? '0
                                                                       : r_rd_ptr + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bf3_back.sv @@
`default_nettype none

module bf3_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire bf3_pkg::t_q_item i_data,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output bf3_pkg::t_out_item    o_out_data
);

    // floor(s / 9) as (s * 7282) >> 16, exact for every window sum
    localparam int DIV_MUL   = 7282;
    localparam int DIV_SHIFT = 16;
    localparam int MUL_W     = bf3_pkg::SUM_W + $clog2(DIV_MUL + 1);

    // 3x3 window, index row*3+col, row 0 on top, col 2 newest
    logic [bf3_pkg::PIX_W-1:0] r_win [9];
    logic [bf3_pkg::PIX_W-1:0] n_win [9];

    logic                      r_b1_valid;
    logic [bf3_pkg::SUM_W-1:0] r_b1_sum;
    logic                      r_b1_last;
    logic                      r_out_valid;
    bf3_pkg::t_out_item        r_out_data;

    logic                      b1_go;
    logic [bf3_pkg::SUM_W-1:0] sum;
    logic [MUL_W-1:0]          prod;

    assign b1_go = r_b1_valid && (!r_out_valid || i_out_ready);
    assign o_pop = i_valid && (!r_b1_valid || b1_go);

    // Window after the shift
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3+0] = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = i_data.up_px;
        n_win[5] = i_data.mid_px;
        n_win[8] = i_data.new_px;
    end

    // Masked sum over the window before or after the shift
    always_comb begin
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (i_data.ctl.row_mask[r] && i_data.ctl.col_mask[c]) begin
                    sum = sum + bf3_pkg::SUM_W'(i_data.ctl.pre ? r_win[r*3+c]
                                                               : n_win[r*3+c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (o_pop) begin
            r_win <= n_win;
        end
    end

    // Sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (o_pop) begin
            r_b1_valid <= i_data.ctl.produced;
        end else if (b1_go) begin
            r_b1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_sum  <= sum;
            r_b1_last <= i_data.ctl.last;
        end
    end

    // Divide by nine into the output register
    assign prod = MUL_W'(r_b1_sum) * MUL_W'(DIV_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_go) begin
            r_out_data.pixel_out     <= bf3_pkg::PIX_W'(prod >> DIV_SHIFT);
            r_out_data.last_of_frame <= r_b1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ rtl/box_filter_3x3_stream.sv @@
// Channel   Direction  Handshake               Payload
// cfg       in         i_cfg_we                i_cfg_index, i_cfg_data
// in        in         i_in_valid/o_in_ready   i_in_data   (t_in_item)
// out       out        o_out_valid/i_out_ready o_out_data  (t_out_item)
//
// One item per cycle while the output is not stalled; each output is registered.
// The rate is set by the line store: one read and one write port, one column per cycle.
// Reset is synchronous; frame size returns to 640 x 480, cursors to the origin.
// A stalled output fills the two-entry queue, then the read stage holds and the
// input stalls; line store contents are undefined after reset and need no clearing.
`default_nettype none

module box_filter_3x3_stream (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [bf3_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire bf3_pkg::t_in_item         i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output bf3_pkg::t_out_item             o_out_data
);

    logic             push;
    bf3_pkg::t_q_item push_data;
    logic             push_ready;
    logic             q_valid;
    bf3_pkg::t_q_item q_data;
    logic             q_pop;

    // Cursor, classification and line stores
    bf3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    // Decoupling queue
    bf3_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_ready     (push_ready),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    // Window, sum and divide
    bf3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_data      (q_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bf3_pkg::*;

    localparam int RAND_ITEMS   = 1350;
    localparam int CALM_AFTER   = 1150;  // no idling on either side past this count
    localparam int SETTLE_CYC   = 8;     // margin after the last pending pixel is out
    localparam int HOLD_AT      = 14;    // result count that starts the long receiver stall
    localparam int LONG_HOLD    = 80;
    localparam int N_DIRECTED   = 25;

    // Directed table: register writes, plain items, and items with a typed-in result
    typedef enum logic [1:0] {STEP_CFG, STEP_ITEM, STEP_CHECK} t_step_kind;

    typedef struct packed {
        t_step_kind       kind;
        logic             idx;
        logic [CFG_W-1:0] data;
        t_in_item         item;
        t_out_item        want;
    } t_step;

    localparam t_step DIRECTED [N_DIRECTED] = '{
        // 0 x 0 is used as 1 x 1
        '{STEP_CFG,   REG_FRAME_WIDTH,  11'd0, '0, '0},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 11'd0, '0, '0},
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_FLUSH, 8'd0},   '0},   // flush too early, dropped
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd255}, '0},
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd7},   '0},   // pixel while draining, dropped
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_FLUSH, 8'd0},   '0},   // one-row frame: nothing yet
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_FLUSH, 8'd0},   {8'd28, 1'b1}},
        // 3 x 3, two pixels in, then a rewrite restarts the frame
        '{STEP_CFG,   REG_FRAME_WIDTH,  11'd3, '0, '0},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 11'd3, '0, '0},
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd0},   '0},
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd0},   '0},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 11'd3, '0, '0},
        // all-white 3 x 3: corners 4/9, edges 6/9, center 9/9 of full scale
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd255}, '0},
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd255}, '0},
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd255}, '0},
        '{STEP_ITEM,  1'b0, 11'd0, {CMD_PIXEL, 8'd255}, '0},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_PIXEL, 8'd255}, {8'd113, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_PIXEL, 8'd255}, {8'd170, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_PIXEL, 8'd255}, {8'd113, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_PIXEL, 8'd255}, {8'd170, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_PIXEL, 8'd255}, {8'd255, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_FLUSH, 8'd0},   {8'd170, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_FLUSH, 8'd0},   {8'd113, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_FLUSH, 8'd0},   {8'd170, 1'b0}},
        '{STEP_CHECK, 1'b0, 11'd0, {CMD_FLUSH, 8'd0},   {8'd113, 1'b1}}
    };

    // DUT ports
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic             i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    t_in_item         i_in_data   = '0;
    logic             i_out_ready = 1'b1;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_item        o_out_data;

    // Shared run state
    t_out_item pending_pixels [$];
    int        fail_count    = 0;
    int        results_taken = 0;
    bit        calm          = 1'b0;
    bit        tx_gappy      = 1'b1;

    // Filter state mirrored by the predictor
    logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
    logic [PIX_W-1:0] upper_row  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_row [MAX_WIDTH];
    logic [PIX_W-1:0] win        [9];     // row*3+col, col 2 newest
    int               in_col = 0;
    int               in_row = 0;

    box_filter_3x3_stream DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // 0 counts as 1, anything above the limit as the limit
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // Sum of window columns c0..2, top window row at image row r0, rows off the frame dropped
    function automatic int window_total(input int c0, input int r0, input int h);
        int s;
        int r;
        int c;
        s = 0;
        for (r = 0; r < 3; r++) begin
            if (r0 + r >= 0 && r0 + r < h) begin
                for (c = c0; c < 3; c++) s += int'(win[r * 3 + c]);
            end
        end
        return s;
    endfunction

    // One accepted item through the mean filter; returns 1 when it yields a pixel
    function automatic bit box_mean_step(input t_in_item it, output t_out_item res);
        int w;
        int h;
        int trow;
        int tcol;
        int total;
        int r;
        bit made;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] px;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        res = '0;
        made = 1'b0;
        total = 0;
        trow = 0;
        tcol = 0;
        // flush only counts once the frame is in, pixels only before
        if (in_row >= h) begin
            if (it.command != CMD_FLUSH) return 1'b0;
            px = '0;
        end else begin
            if (it.command == CMD_FLUSH) return 1'b0;
            px = it.pixel_in;
        end
        // column 0 finishes the right edge of the row two above, from the old window
        if (in_col == 0) begin
            trow = in_row - 2;
            tcol = w - 1;
            if (trow >= 0) begin
                total = window_total(w >= 2 ? 1 : 2, in_row - 3, h);
                made = 1'b1;
            end
        end
        a = upper_row[in_col];
        b = middle_row[in_col];
        upper_row[in_col] = b;
        middle_row[in_col] = px;
        for (r = 0; r < 3; r++) begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = a;
        win[5] = b;
        win[8] = px;
        if (in_col >= 1) begin
            trow = in_row - 1;
            tcol = in_col - 1;
            if (trow >= 0) begin
                total = window_total(in_col >= 2 ? 0 : 1, in_row - 2, h);
                made = 1'b1;
            end
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!made) return 1'b0;
        res.pixel_out = PIX_W'(total / 9);
        res.last_of_frame = (trow == h - 1 && tcol == w - 1);
        if (res.last_of_frame) begin
            in_col = 0;
            in_row = 0;
        end
        return 1'b1;
    endfunction

    // Drop valid and hold it low for the pause given by n
    task automatic sender_pause(input int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offer one item, wait for its transfer, then log what it should yield
    task automatic offer(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        bit made;
        if (!calm && tx_gappy && $urandom_range(0, 3) == 0) sender_pause($urandom_range(1, 3));
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        made = box_mean_step(it, res);
        if (typed) pending_pixels.push_back(typed_res);
        else if (made) pending_pixels.push_back(res);
    endtask

    // Hold the input until every pending pixel is out, then let the pipe settle
    task automatic wait_drained();
        sender_pause(1);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic frame_cfg_write(input logic idx, input logic [CFG_W-1:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
        in_col = 0;
        in_row = 0;
    endtask

    // Output side: check every transfer against the oldest pending pixel
    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_taken++;
            if (pending_pixels.size() == 0) begin
                $error("pixel_out: unexpected result %0d (last_of_frame %0b)",
                       o_out_data.pixel_out, o_out_data.last_of_frame);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_data.pixel_out !== want.pixel_out) begin
                    $error("pixel_out: expected %0d, got %0d",
                           want.pixel_out, o_out_data.pixel_out);
                    fail_count++;
                end
                if (o_out_data.last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0b, got %0b",
                           want.last_of_frame, o_out_data.last_of_frame);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: short random stalls in some stretches, one long stall to back up the input
    initial begin : rx_side
        int gap;
        int span;
        bit rx_gappy;
        bit held;
        gap = 0;
        span = 0;
        rx_gappy = 1'b1;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            span++;
            if (span == 50) begin
                span = 0;
                rx_gappy = ($urandom_range(0, 2) != 0);
            end
            if (!held && results_taken >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (gap > 0) begin
                i_out_ready <= 1'b0;
                gap--;
            end else if (!calm && rx_gappy && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                gap = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : run_limit
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Stimulus
    initial begin : stim
        int i;
        int k;
        int w;
        int h;
        int frame_no;
        int random_items;
        int abort_at;
        bit partial;
        bit need_cfg;
        bit aborted;
        logic [PIX_W-1:0] px;
        for (i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (i = 0; i < 9; i++) win[i] = '0;
        frame_no = 0;
        random_items = 0;
        need_cfg = 1'b1;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].kind == STEP_CFG)
                frame_cfg_write(DIRECTED[i].idx, DIRECTED[i].data);
            else
                offer(DIRECTED[i].item, DIRECTED[i].kind == STEP_CHECK, DIRECTED[i].want);
        end

        // random frames: mostly whole frames with random content, some noise and aborts
        while (random_items < RAND_ITEMS) begin
            tx_gappy = ($urandom_range(0, 2) != 0);
            partial = 1'b0;
            if (frame_no == 0) begin
                // mid-size frame so the long receiver stall backs up the input
                frame_cfg_write(REG_FRAME_WIDTH, 11'd8);
                frame_cfg_write(REG_FRAME_HEIGHT, 11'd6);
            end else if (frame_no == 2) begin
                // width above the limit, single row, cut short after a stretch of pixels
                frame_cfg_write(REG_FRAME_WIDTH, CFG_W'($urandom_range(1025, 2047)));
                frame_cfg_write(REG_FRAME_HEIGHT, 11'd1);
                partial = 1'b1;
            end else if (frame_no == 4) begin
                // height above the limit, single column, cut short after a stretch of pixels
                frame_cfg_write(REG_FRAME_WIDTH, 11'd0);
                frame_cfg_write(REG_FRAME_HEIGHT, CFG_W'($urandom_range(1025, 2047)));
                partial = 1'b1;
            end else begin
                if (need_cfg || $urandom_range(0, 1) == 1)
                    frame_cfg_write(REG_FRAME_WIDTH, ($urandom_range(0, 5) == 0) ?
                                    CFG_W'($urandom_range(0, 40)) :
                                    CFG_W'($urandom_range(1, 12)));
                if (need_cfg || $urandom_range(0, 1) == 1)
                    frame_cfg_write(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 6)));
            end
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            if (partial)
                abort_at = int'($urandom_range(20, 60));
            else if ($urandom_range(0, 11) == 0)
                abort_at = int'($urandom_range(0, w * h - 1));
            else
                abort_at = -1;
            aborted = 1'b0;

            for (k = 0; k < w * h && !aborted; k++) begin
                if ($urandom_range(0, 24) == 0)
                    offer({CMD_FLUSH, PIX_W'($urandom_range(0, 255))}, 1'b0, '0);
                px = ($urandom_range(0, 7) == 0) ? {PIX_W{$urandom_range(0, 1) == 1}} :
                     PIX_W'($urandom_range(0, 255));
                offer({CMD_PIXEL, px}, 1'b0, '0);
                random_items++;
                if (k == abort_at) aborted = 1'b1;
            end

            // drain: one flush per column plus one, with the odd stray pixel
            if (!aborted) begin
                for (k = 0; k <= w; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        offer({CMD_PIXEL, PIX_W'($urandom_range(0, 255))}, 1'b0, '0);
                    offer({CMD_FLUSH, PIX_W'($urandom_range(0, 255))}, 1'b0, '0);
                    random_items++;
                end
            end
            need_cfg = aborted;
            if (random_items >= CALM_AFTER) calm = 1'b1;
            frame_no++;
        end

        wait_drained();
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
